// File: sv/gisa_pkg.sv
// ---------------------------------------------------------------------------
// gisa_pkg: shared types and constants for the grouped integer sum core
// Word layouts, the decoded operation code and the back-end state type.
// ---------------------------------------------------------------------------
package gisa_pkg;

    // Default number of groups and the group field width
    localparam int GISA_GROUPS  = 256;
    localparam int GISA_GRP_W   = 8;
    localparam int GISA_DATA_W  = 32;

    // Missing marker: the most negative 32-bit value
    localparam logic [GISA_DATA_W-1:0] GISA_MARK = {1'b1, {(GISA_DATA_W-1){1'b0}}};

    // Function codes carried on the input word
    localparam logic [1:0] FUNC_ACC   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]                    func;
        logic [GISA_GRP_W-1:0]         group;
        logic signed [GISA_DATA_W-1:0] sample;
    } gisa_in_t;

    typedef struct packed {
        logic signed [GISA_DATA_W-1:0] total;
        logic                          missing;
        logic                          status;
    } gisa_out_t;

    // Operation decided by the front end
    typedef enum logic [1:0] {
        OP_ACC,
        OP_READ,
        OP_CLEAR,
        OP_SKIP
    } gisa_op_t;

    // Word passed from front end to back end
    typedef struct packed {
        gisa_op_t                      op;
        logic [GISA_GRP_W-1:0]         group;
        logic signed [GISA_DATA_W-1:0] sample;
    } gisa_cmd_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_HOLD
    } gisa_state_t;

endpackage

// File: sv/gisa_ram.sv
// ---------------------------------------------------------------------------
// gisa_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module gisa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/gisa_front.sv
// ---------------------------------------------------------------------------
// gisa_front: input acceptance, decode and command queue
// Classifies each input word and holds up to two commands for the back end.
// ---------------------------------------------------------------------------
module gisa_front
    import gisa_pkg::*;
#(
    parameter int GROUPS = GISA_GROUPS
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  gisa_in_t  in_data,
    output logic      q_valid,
    output gisa_cmd_t q_data,
    input  logic      q_pop
);

    localparam int QDEPTH = 2;

    gisa_cmd_t   mem_reg [QDEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    gisa_cmd_t   cmd;
    logic        push;
    logic        pop;

    // Decode the function code and range-check the group
    always_comb
    begin
        cmd.group  = in_data.group;
        cmd.sample = in_data.sample;
        if (32'(in_data.group) >= GROUPS)
        begin
            cmd.op = OP_SKIP;
        end
        else
        begin
            unique case (in_data.func)
                FUNC_ACC:   cmd.op = OP_ACC;
                FUNC_CLEAR: cmd.op = OP_CLEAR;
                default:    cmd.op = OP_READ;
            endcase
        end
    end

    assign in_ready = (cnt_reg != 2'(QDEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_data   = mem_reg[rd_ptr_reg];

    // Advance queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the decoded word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

// File: sv/gisa_back.sv
// ---------------------------------------------------------------------------
// gisa_back: read-modify-write engine over the group total table
// Looks up the group entry, applies the operation, writes back, presents result.
// ---------------------------------------------------------------------------
module gisa_back
    import gisa_pkg::*;
#(
    parameter int GROUPS = GISA_GROUPS
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      skip_missing,
    input  logic      q_valid,
    input  gisa_cmd_t q_data,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_ready,
    output gisa_out_t out_data
);

    localparam int IDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    gisa_state_t             state_reg, state_next;
    gisa_cmd_t               cmd_reg;
    gisa_out_t               out_reg, out_next;
    logic [GROUPS-1:0]       vld_reg;
    logic [IDX_W-1:0]        rd_idx;
    logic [IDX_W-1:0]        cur_idx;
    logic                    ram_re;
    logic                    ram_we;
    logic [GISA_DATA_W-1:0]  ram_rdata;
    logic [GISA_DATA_W-1:0]  entry;
    logic [GISA_DATA_W-1:0]  new_entry;
    logic [GISA_DATA_W:0]    sum;
    logic                    ovf;
    logic                    load_cmd;
    logic                    load_out;

    assign rd_idx  = IDX_W'(q_data.group);
    assign cur_idx = IDX_W'(cmd_reg.group);

    gisa_ram #(
        .WIDTH (GISA_DATA_W),
        .DEPTH (GROUPS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cur_idx),
        .wdata (new_entry),
        .re    (ram_re),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    // Entries never written read as zero
    always_comb
    begin
        entry = GISA_DATA_W'(0);
        if (cmd_reg.op != OP_SKIP && vld_reg[cur_idx])
        begin
            entry = ram_rdata;
        end
    end

    // Signed add with range check; the marker value counts as overflow
    assign sum = {entry[GISA_DATA_W-1], entry} +
                 {cmd_reg.sample[GISA_DATA_W-1], cmd_reg.sample};
    assign ovf = (sum[GISA_DATA_W] != sum[GISA_DATA_W-1]) ||
                 (sum[GISA_DATA_W-1:0] == GISA_MARK);

    // Work out the new entry and the result word
    always_comb
    begin
        new_entry = entry;
        out_next  = '0;
        case (cmd_reg.op)
            OP_CLEAR:
            begin
                new_entry = skip_missing ? GISA_MARK : GISA_DATA_W'(0);
            end
            OP_ACC:
            begin
                if (cmd_reg.sample == GISA_MARK)
                begin
                    if (!skip_missing)
                    begin
                        new_entry = GISA_MARK;
                    end
                end
                else if (entry == GISA_MARK)
                begin
                    if (skip_missing)
                    begin
                        new_entry = cmd_reg.sample;
                    end
                end
                else if (!ovf)
                begin
                    new_entry = sum[GISA_DATA_W-1:0];
                end
            end
            default:
            begin
                new_entry = entry;
            end
        endcase
        if (cmd_reg.op != OP_SKIP)
        begin
            out_next.total   = new_entry;
            out_next.missing = (new_entry == GISA_MARK);
            out_next.status  = (cmd_reg.op == OP_ACC) && (cmd_reg.sample != GISA_MARK) &&
                               (entry != GISA_MARK) && ovf;
        end
    end

    // Sequence: take a word and read, update and write back, hold the result
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        load_cmd   = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    ram_re     = 1'b1;
                    load_cmd   = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                ram_we     = (cmd_reg.op == OP_ACC) || (cmd_reg.op == OP_CLEAR);
                load_out   = 1'b1;
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vld_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_we)
            begin
                vld_reg[cur_idx] <= 1'b1;
            end
        end
    end

    // Hold the current word and the result
    always_ff @(posedge clk)
    begin
        if (load_cmd)
        begin
            cmd_reg <= q_data;
        end
        if (load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = (state_reg == ST_HOLD);
    assign out_data  = out_reg;

endmodule

// File: sv/grouped_integer_sum_accumulator_core.sv
// Grouped signed sum accumulator. Each input word clears, adds to or reads one
// of GROUPS signed 32-bit totals and yields one result word. The back end does
// a read-modify-write on the total table (table read, update and write-back,
// then result handoff) and takes no new word until the result of the last one
// is taken; a two-entry queue in front lets the input side keep accepting
// while a result waits. Totals that were never written read as zero through
// per-entry valid bits cleared at reset, so no clearing pass is needed.
// Groups at or above GROUPS give an all-zero result.
// ---------------------------------------------------------------------------
// grouped_integer_sum_accumulator_core: top level
// Connects the front-end queue, the update engine and the config register.
// ---------------------------------------------------------------------------
module grouped_integer_sum_accumulator_core
    import gisa_pkg::*;
#(
    parameter int GROUPS = GISA_GROUPS
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    input  logic      in_valid,
    output logic      in_ready,
    input  gisa_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output gisa_out_t out_data
);

    logic      skip_missing_reg;
    logic      q_valid;
    logic      q_pop;
    gisa_cmd_t q_data;

    // Hold the skip-missing mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_missing_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            skip_missing_reg <= cfg_wdata;
        end
    end

    gisa_front #(
        .GROUPS (GROUPS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    gisa_back #(
        .GROUPS (GROUPS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .skip_missing (skip_missing_reg),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

endmodule
